[rtl/pretrigger_capture_buffer_macros.svh]
// Assertion helpers; each expects clk_i and rst_ni in the enclosing module.
`ifndef PRETRIGGER_CAPTURE_BUFFER_MACROS_SVH
`define PRETRIGGER_CAPTURE_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

`define PCB_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("pcb assertion failed");

`define PCB_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pcb implication failed");

`define PCB_IMPLY_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pcb next-cycle implication failed");

`else

`define PCB_ASSERT(lbl, cond)

`define PCB_IMPLY(lbl, pre, post)

`define PCB_IMPLY_NEXT(lbl, pre, post)

`endif

`endif

[rtl/pcb_pkg.sv]
`default_nettype none

package pcb_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int OP_W        = 2;
  localparam int START_W     = 6;
  localparam int INDEX_W     = 6;
  localparam int TIME_W      = 11;
  localparam int SCALE_W     = 14;
  localparam int PROD_W      = SAMPLE_W + SCALE_W;
  localparam int SCALE_SHIFT = 15;

  localparam logic [SCALE_W-1:0] SCALE_NUM = 14'd10480;
  localparam logic [TIME_W-1:0]  TIME_STEP = 11'd21;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_MARK   = 2'd1,
    OP_ARM    = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [SAMPLE_W-1:0] pressure;
    logic [START_W-1:0]  dump_start;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_t;

endpackage

`default_nettype wire

[rtl/pcb_in_if.sv]
`default_nettype none

interface pcb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] pressure;
  logic [5:0]  dump_start;

  modport source (output valid, output op, output pressure, output dump_start, input ready);
  modport sink (input valid, input op, input pressure, input dump_start, output ready);
endinterface

`default_nettype wire

[rtl/pcb_out_if.sv]
`default_nettype none

interface pcb_out_if;
  logic               valid;
  logic               ready;
  logic               loop_complete;
  logic [15:0]        last_sample;
  logic               registering;
  logic [5:0]         dump_index;
  logic [10:0]        elapsed_time;
  logic signed [15:0] scaled_value;
  logic               last;

  modport source (
    output valid, output loop_complete, output last_sample, output registering,
    output dump_index, output elapsed_time, output scaled_value, output last,
    input ready
  );
  modport sink (
    input valid, input loop_complete, input last_sample, input registering,
    input dump_index, input elapsed_time, input scaled_value, input last,
    output ready
  );
endinterface

`default_nettype wire

[rtl/pcb_ram.sv]
`default_nettype none

module pcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/pcb_front.sv]
`default_nettype none

module pcb_front import pcb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  pcb_in_if.sink   in_i,
  input  logic     pop_i,
  output q_t       head_o
);

  cmd_t       ent_q [2];
  cmd_t       cmd;
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  // classify
  always_comb begin
    cmd.op         = op_e'(in_i.op);
    cmd.pressure   = in_i.pressure;
    cmd.dump_start = in_i.dump_start;
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cmd;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = ent_q[rd_q];

endmodule

`default_nettype wire

[rtl/pcb_back.sv]
`default_nettype none
`include "pretrigger_capture_buffer_macros.svh"

module pcb_back import pcb_pkg::*; #(
  parameter int BUFFER_DEPTH     = 64,
  parameter int PRETRIGGER_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_t       fifo_i,
  output logic     pop_o,
  pcb_out_if.source out_o
);

  localparam int AW     = $clog2(BUFFER_DEPTH);
  localparam int PW     = $clog2(PRETRIGGER_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(PRETRIGGER_DEPTH);
  localparam int RCP_SH = SUM_W + $clog2(PRETRIGGER_DEPTH);
  localparam int RCP_W  = SUM_W + 2;
  localparam int DP_W   = SUM_W + RCP_W;
  localparam int BACK   = PRETRIGGER_DEPTH % BUFFER_DEPTH;

  localparam logic [AW-1:0]    LAST_POS  = AW'(BUFFER_DEPTH - 1);
  localparam logic [AW-1:0]    BACK_A    = AW'(BACK);
  localparam logic [AW-1:0]    FWD_A     = AW'(BUFFER_DEPTH - BACK);
  localparam logic [PW-1:0]    LAST_PRE  = PW'(PRETRIGGER_DEPTH - 1);
  localparam logic [START_W:0] DEPTH_EXT = (START_W + 1)'(BUFFER_DEPTH);
  localparam logic [63:0]      RCP_FULL  = ((64'd1 << RCP_SH) + 64'(PRETRIGGER_DEPTH) - 64'd1)
                                           / 64'(PRETRIGGER_DEPTH);
  localparam logic [RCP_W-1:0] RECIP     = RCP_W'(RCP_FULL);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_WRAP = 8'b0000_0010,
    S_SRD  = 8'b0000_0100,
    S_SACC = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_ERD  = 8'b0010_0000,
    S_EMUL = 8'b0100_0000,
    S_EOUT = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic                       loop_complete;
    logic [SAMPLE_W-1:0]        last_sample;
    logic                       registering;
    logic [INDEX_W-1:0]         dump_index;
    logic [TIME_W-1:0]          elapsed_time;
    logic signed [SAMPLE_W-1:0] scaled_value;
    logic                       last;
  } res_t;

  state_e              state_q, state_d;
  logic [AW-1:0]       wpos_q, wpos_d;
  logic [AW-1:0]       mark_q, mark_d;
  logic                flag_q, flag_d;
  logic [SAMPLE_W-1:0] last_q, last_d;
  logic [BUFFER_DEPTH-1:0] vld_q, vld_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic                out_valid_q, out_valid_d;

  logic [START_W-1:0]  start_q, start_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [PW-1:0]       pre_cnt_q, pre_cnt_d;
  logic [SAMPLE_W-1:0] avg_q, avg_d;
  logic                rd_vld_q, rd_vld_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic                neg_q, neg_d;
  res_t                res_q, res_d;

  logic                ram_we;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] quot;
  logic [AW-1:0]       wpos_next;
  logic [AW-1:0]       addr_next;
  logic [AW-1:0]       mark_calc;
  logic [DP_W-1:0]     div_prod;
  logic                out_free;

  pcb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (fifo_i.cmd.pressure),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign sample    = rd_vld_q ? ram_rdata : '0;
  assign wpos_next = (wpos_q == LAST_POS) ? '0 : wpos_q + 1'b1;
  assign addr_next = (addr_q == LAST_POS) ? '0 : addr_q + 1'b1;
  assign mark_calc = (wpos_q >= BACK_A) ? wpos_q - BACK_A : wpos_q + FWD_A;
  assign div_prod  = DP_W'(sum_q) * DP_W'(RECIP);
  assign mag       = neg_q ? '0 : '0;
  assign quot      = SAMPLE_W'(prod_q[PROD_W-1:SCALE_SHIFT]);
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    wpos_d      = wpos_q;
    mark_d      = mark_q;
    flag_d      = flag_q;
    last_d      = last_q;
    vld_d       = vld_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    start_d     = start_q;
    sum_d       = sum_q;
    pre_cnt_d   = pre_cnt_q;
    avg_d       = avg_q;
    rd_vld_d    = rd_vld_q;
    idx_d       = idx_q;
    time_d      = time_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    res_d       = res_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (fifo_i.valid && out_free) begin
          pop_o              = 1'b1;
          res_d.loop_complete = 1'b0;
          res_d.dump_index   = '0;
          res_d.elapsed_time = '0;
          res_d.scaled_value = '0;
          res_d.last         = 1'b1;
          unique case (fifo_i.cmd.op)
            OP_SAMPLE: begin
              ram_we              = 1'b1;
              vld_d[wpos_q]       = 1'b1;
              last_d              = fifo_i.cmd.pressure;
              wpos_d              = wpos_next;
              out_valid_d         = 1'b1;
              res_d.loop_complete = flag_q && (wpos_next == mark_q);
            end
            OP_MARK: begin
              mark_d      = mark_calc;
              out_valid_d = 1'b1;
            end
            OP_ARM: begin
              flag_d      = 1'b1;
              out_valid_d = 1'b1;
            end
            OP_DUMP: begin
              start_d = fifo_i.cmd.dump_start;
              state_d = S_WRAP;
            end
            default: begin
            end
          endcase
          res_d.last_sample = last_d;
          res_d.registering = flag_d;
        end
      end
      S_WRAP: begin
        if ((START_W + 1)'(start_q) >= DEPTH_EXT) begin
          start_d = START_W'((START_W + 1)'(start_q) - DEPTH_EXT);
        end else begin
          addr_d    = AW'(start_q);
          sum_d     = '0;
          pre_cnt_d = '0;
          state_d   = S_SRD;
        end
      end
      S_SRD: begin
        rd_vld_d = vld_q[addr_q];
        state_d  = S_SACC;
      end
      S_SACC: begin
        sum_d  = sum_q + SUM_W'(sample);
        addr_d = addr_next;
        if (pre_cnt_q == LAST_PRE) begin
          state_d = S_DIV;
        end else begin
          pre_cnt_d = pre_cnt_q + 1'b1;
          state_d   = S_SRD;
        end
      end
      S_DIV: begin
        avg_d   = div_prod[RCP_SH +: SAMPLE_W];
        addr_d  = AW'(start_q);
        idx_d   = '0;
        time_d  = '0;
        state_d = S_ERD;
      end
      S_ERD: begin
        rd_vld_d = vld_q[addr_q];
        state_d  = S_EMUL;
      end
      S_EMUL: begin
        neg_d   = (sample < avg_q);
        prod_d  = PROD_W'((sample < avg_q) ? avg_q - sample : sample - avg_q)
                  * PROD_W'(SCALE_NUM);
        state_d = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          res_d.loop_complete = 1'b0;
          res_d.last_sample   = last_q;
          res_d.registering   = flag_q;
          res_d.dump_index    = INDEX_W'(idx_q);
          res_d.elapsed_time  = time_q;
          res_d.scaled_value  = neg_q ? $signed(SAMPLE_W'(0) - quot) : $signed(quot);
          res_d.last          = (idx_q == LAST_POS);
          if (idx_q == LAST_POS) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            addr_d  = addr_next;
            time_d  = time_q + TIME_STEP;
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wpos_q      <= '0;
      mark_q      <= '0;
      flag_q      <= 1'b0;
      last_q      <= '0;
      vld_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      mark_q      <= mark_d;
      flag_q      <= flag_d;
      last_q      <= last_d;
      vld_q       <= vld_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    sum_q     <= sum_d;
    pre_cnt_q <= pre_cnt_d;
    avg_q     <= avg_d;
    rd_vld_q  <= rd_vld_d;
    idx_q     <= idx_d;
    time_q    <= time_d;
    prod_q    <= prod_d;
    neg_q     <= neg_d;
    res_q     <= res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.loop_complete = res_q.loop_complete;
  assign out_o.last_sample   = res_q.last_sample;
  assign out_o.registering   = res_q.registering;
  assign out_o.dump_index    = res_q.dump_index;
  assign out_o.elapsed_time  = res_q.elapsed_time;
  assign out_o.scaled_value  = res_q.scaled_value | $signed(mag);
  assign out_o.last          = res_q.last;

  `PCB_ASSERT(a_addr_range, 32'(addr_q) < BUFFER_DEPTH)
  `PCB_ASSERT(a_pos_range, (32'(wpos_q) < BUFFER_DEPTH) && (32'(mark_q) < BUFFER_DEPTH))
  `PCB_IMPLY(a_pop_idle, pop_o, fifo_i.valid && (state_q == S_IDLE))
  `PCB_IMPLY_NEXT(a_dump_enter, pop_o && (fifo_i.cmd.op == OP_DUMP), state_q == S_WRAP)

endmodule

`default_nettype wire

[rtl/pretrigger_capture_buffer.sv]
// Ring capture store of BUFFER_DEPTH pressure samples with a pretrigger start
// mark. Items enter a two-entry queue and retire one per cycle while the
// output is free for sample, mark and arm operations (one result each,
// registered in the result register after the queue entry). A dump walks the
// sample RAM through its single read port: it folds dump_start into range by
// subtracting BUFFER_DEPTH, reads and accumulates each pretrigger sample for
// the baseline sum, forms the average with a reciprocal multiply, then reads,
// scale-multiplies and outputs each emitted sample.
// The store reads as zero after reset through per-entry valid flops; there
// is no clearing pass.
`default_nettype none

module pretrigger_capture_buffer import pcb_pkg::*; #(
  parameter int BUFFER_DEPTH     = 64,
  parameter int PRETRIGGER_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcb_in_if.sink    in_i,
  pcb_out_if.source out_o
);

  q_t   head;
  logic pop;

  pcb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .head_o (head)
  );

  pcb_back #(
    .BUFFER_DEPTH     (BUFFER_DEPTH),
    .PRETRIGGER_DEPTH (PRETRIGGER_DEPTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fifo_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
